@@ src/crt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crt_pkg: shared types and constants of the command retry tracker
// Packet type codes, completion codes, register indexes and the word passed
// from the classifier to the execution stage.
// ----------------------------------------------------------------------------
package crt_pkg;

    localparam int unsigned MAX_BODY = 64;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int unsigned S_TDATA_W = 128;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 40;

    // input word kinds
    localparam logic [1:0] FUNC_SEND = 2'd0;
    localparam logic [1:0] FUNC_TICK = 2'd1;
    localparam logic [1:0] FUNC_RECV = 2'd2;

    // packet types
    localparam logic [2:0] TYPE_PING  = 3'd0;
    localparam logic [2:0] TYPE_ACK   = 3'd3;
    localparam logic [2:0] TYPE_ERROR = 3'd4;

    // completion codes
    localparam logic [1:0] RES_OK      = 2'd0;
    localparam logic [1:0] RES_ERR     = 2'd1;
    localparam logic [1:0] RES_TIMEOUT = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_OWN_ADDR   = 2'd0;
    localparam logic [1:0] CFG_HUB_ADDR   = 2'd1;
    localparam logic [1:0] CFG_BCAST_ADDR = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SEND,
        OP_TICK,
        OP_PING,
        OP_REPLY
    } crt_op_t;

    // classified word handed to the back end
    typedef struct packed {
        crt_op_t     op;
        logic        is_err;
        logic [2:0]  typ;
        logic [7:0]  code;
        logic [7:0]  seq;
        logic [7:0]  src;
        logic [31:0] wait_ms;
        logic [7:0]  retry;
        logic [31:0] now_ms;
    } crt_item_t;

    typedef struct packed {
        logic        accepted;
        logic        tx_valid;
        logic [7:0]  tx_dst;
        logic [2:0]  tx_type;
        logic [7:0]  tx_cmd;
        logic [7:0]  tx_seq;
        logic        done_valid;
        logic [1:0]  done_result;
        logic        busy_res;
    } crt_result_t;

endpackage
`default_nettype wire

@@ src/crt_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crt_front: input classifier
// Decodes an incoming word into an operation and turns words that can have
// no effect (overlong bodies, broadcast pings, unknown kinds) into no-ops.
// ----------------------------------------------------------------------------
module crt_front
    import crt_pkg::*;
(
    input  wire logic [1:0]  func,
    input  wire logic [2:0]  cmd_type,
    input  wire logic [7:0]  cmd_code,
    input  wire logic [7:0]  body_length,
    input  wire logic [31:0] wait_ms,
    input  wire logic [7:0]  retry_count,
    input  wire logic [31:0] now_ms,
    input  wire logic [2:0]  pkt_type,
    input  wire logic [7:0]  pkt_cmd,
    input  wire logic [7:0]  pkt_seq,
    input  wire logic [7:0]  pkt_src,
    input  wire logic [7:0]  pkt_dst,
    input  wire logic [7:0]  broadcast_address,
    output crt_item_t        item
);

    logic body_ok;

    assign body_ok = ({1'b0, body_length} <= 9'(MAX_BODY));

    always_comb begin
        item         = '0;
        item.op      = OP_NONE;
        item.wait_ms = wait_ms;
        item.retry   = retry_count;
        item.now_ms  = now_ms;
        item.seq     = pkt_seq;
        item.src     = pkt_src;
        item.is_err  = (pkt_type == TYPE_ERROR);
        unique case (func)
            FUNC_SEND: begin
                item.typ  = cmd_type;
                item.code = cmd_code;
                if (body_ok) begin
                    item.op = OP_SEND;
                end
            end
            FUNC_TICK: begin
                item.op = OP_TICK;
            end
            FUNC_RECV: begin
                item.code = pkt_cmd;
                if (pkt_type == TYPE_PING) begin
                    if (pkt_dst != broadcast_address) begin
                        item.op = OP_PING;
                    end
                end else if (pkt_type == TYPE_ACK || pkt_type == TYPE_ERROR) begin
                    item.op = OP_REPLY;
                end
            end
            default: begin
                item.op = OP_NONE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ src/crt_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crt_queue: short queue between classifier and execution stage
// Flip-flop FIFO; push and pop in the same cycle keep the level while the
// queue is neither empty nor full.
module crt_queue
    import crt_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire crt_item_t push_item,
    output logic           full,
    input  wire logic      pop,
    output logic           empty,
    output crt_item_t      pop_item
);

    crt_item_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]   count_reg, count_next;
    logic                     do_push, do_pop;

    assign full     = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue level beyond depth");

    a_level_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue level missed a push");

endmodule
`default_nettype wire

@@ src/crt_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crt_back: request tracker and result register
// Holds the outstanding request, its deadline and retry budget; executes one
// queued word per cycle, while the result register is free or being taken,
// into a result register.
module crt_back
    import crt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [7:0]  hub_address,
    input  wire logic        q_empty,
    input  wire crt_item_t   q_item,
    output logic             q_pop,
    output logic             res_valid,
    input  wire logic        res_ready,
    output crt_result_t      res
);

    logic        outstanding_reg, outstanding_next;
    logic [2:0]  saved_type_reg, saved_type_next;
    logic [7:0]  saved_cmd_reg, saved_cmd_next;
    logic [7:0]  saved_seq_reg, saved_seq_next;
    logic [7:0]  next_seq_reg, next_seq_next;
    logic [7:0]  retries_reg, retries_next;
    logic [31:0] deadline_reg, deadline_next;
    logic [31:0] attempt_wait_reg, attempt_wait_next;
    logic        res_valid_reg;
    crt_result_t res_reg, res_next;
    logic [31:0] diff;
    logic        expired;

    // result slot frees when empty or being taken
    assign q_pop     = !q_empty && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // wrap-safe: at or past the deadline when the difference is non-negative
    assign diff    = q_item.now_ms - deadline_reg;
    assign expired = !diff[31];

    always_comb begin
        outstanding_next  = outstanding_reg;
        saved_type_next   = saved_type_reg;
        saved_cmd_next    = saved_cmd_reg;
        saved_seq_next    = saved_seq_reg;
        next_seq_next     = next_seq_reg;
        retries_next      = retries_reg;
        deadline_next     = deadline_reg;
        attempt_wait_next = attempt_wait_reg;
        res_next          = '0;
        unique case (q_item.op)
            OP_SEND: begin
                if (!outstanding_reg) begin
                    saved_type_next     = q_item.typ;
                    saved_cmd_next      = q_item.code;
                    saved_seq_next      = next_seq_reg;
                    next_seq_next       = next_seq_reg + 8'd1;
                    retries_next        = q_item.retry;
                    attempt_wait_next   = q_item.wait_ms;
                    deadline_next       = q_item.now_ms + q_item.wait_ms;
                    outstanding_next    = 1'b1;
                    res_next.accepted   = 1'b1;
                    res_next.tx_valid   = 1'b1;
                    res_next.tx_dst     = hub_address;
                    res_next.tx_type    = q_item.typ;
                    res_next.tx_cmd     = q_item.code;
                    res_next.tx_seq     = next_seq_reg;
                end
            end
            OP_TICK: begin
                if (outstanding_reg && expired) begin
                    if (retries_reg != '0) begin
                        retries_next      = retries_reg - 8'd1;
                        deadline_next     = q_item.now_ms + attempt_wait_reg;
                        res_next.tx_valid = 1'b1;
                        res_next.tx_dst   = hub_address;
                        res_next.tx_type  = saved_type_reg;
                        res_next.tx_cmd   = saved_cmd_reg;
                        res_next.tx_seq   = saved_seq_reg;
                    end else begin
                        outstanding_next     = 1'b0;
                        res_next.done_valid  = 1'b1;
                        res_next.done_result = RES_TIMEOUT;
                    end
                end
            end
            OP_PING: begin
                res_next.tx_valid = 1'b1;
                res_next.tx_dst   = q_item.src;
                res_next.tx_type  = TYPE_ACK;
                res_next.tx_cmd   = q_item.code;
                res_next.tx_seq   = q_item.seq;
            end
            OP_REPLY: begin
                if (outstanding_reg && q_item.code == saved_cmd_reg
                        && q_item.seq == saved_seq_reg) begin
                    outstanding_next     = 1'b0;
                    res_next.done_valid  = 1'b1;
                    res_next.done_result = q_item.is_err ? RES_ERR : RES_OK;
                end
            end
            default: begin
                res_next = '0;
            end
        endcase
        res_next.busy_res = outstanding_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outstanding_reg  <= 1'b0;
            saved_type_reg   <= '0;
            saved_cmd_reg    <= '0;
            saved_seq_reg    <= '0;
            next_seq_reg     <= 8'd1;
            retries_reg      <= '0;
            deadline_reg     <= '0;
            attempt_wait_reg <= '0;
            res_valid_reg    <= 1'b0;
        end else begin
            if (q_pop) begin
                outstanding_reg  <= outstanding_next;
                saved_type_reg   <= saved_type_next;
                saved_cmd_reg    <= saved_cmd_next;
                saved_seq_reg    <= saved_seq_next;
                next_seq_reg     <= next_seq_next;
                retries_reg      <= retries_next;
                deadline_reg     <= deadline_next;
                attempt_wait_reg <= attempt_wait_next;
                res_valid_reg    <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            res_reg <= res_next;
        end
    end

    a_tx_or_done: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_reg |-> !(res_reg.tx_valid && res_reg.done_valid))
        else $error("transmit and completion in one word");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_reg && res_reg.accepted) |-> res_reg.busy_res)
        else $error("accepted send left tracker idle");

    a_done_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(outstanding_reg) |-> (res_reg.done_valid && res_valid_reg))
        else $error("request dropped without completion");

    a_seq_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(outstanding_reg) |-> (next_seq_reg == $past(next_seq_reg) + 8'd1))
        else $error("sequence number not advanced on accept");

endmodule
`default_nettype wire

@@ src/command_retry_tracker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// command_retry_tracker: stop-and-wait request tracker with retransmission
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per event; s_tuser selects send, tick or received
//   packet, s_tdata carries the request and packet fields.
//   m_ channel: exactly one result word per input word, in order, giving
//   accept/transmit/completion flags and the header to transmit.
//   cfg channel: register writes (hub and broadcast address), always ready;
//   write only while no words are in flight.
// Path: a word goes through the classifier into the queue, then through the
//   tracker into the result register.
// Throughput: one word per cycle while the result register is free or being
//   taken; the tracker update is two 32-bit adds and one 32-bit compare.
// Stall: the result register holds while m_tready is low; the two-word queue
//   absorbs input until full, then s_tready drops.
// Reset: aresetn low clears the queue, the result valid flag and the tracker
//   (nothing outstanding, next sequence number 1) and restores registers.
// ----------------------------------------------------------------------------
module command_retry_tracker
    import crt_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // cmd_type, cmd_code, body_length, wait_ms, retry_count, now_ms,
    // pkt_type, pkt_cmd, pkt_seq, pkt_src, pkt_dst, zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // func
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // accepted, tx_valid, tx_dst, tx_type, tx_cmd, tx_seq, done_valid,
    // done_result, busy_res, zero pad
    output logic [M_TDATA_W-1:0]      m_tdata,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [7:0]           cfg_data
);

    logic [7:0]  hub_address_reg;
    logic [7:0]  bcast_address_reg;
    crt_item_t   front_item;
    crt_item_t   q_item;
    logic        q_full, q_empty, q_pop;
    crt_result_t res;

    assign cfg_ready = 1'b1;

    // own address feeds no output here, so its writes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hub_address_reg   <= 8'd0;
            bcast_address_reg <= 8'd255;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_HUB_ADDR:   hub_address_reg   <= cfg_data;
                CFG_BCAST_ADDR: bcast_address_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    crt_front u_front (
        .func              (s_tuser[1:0]),
        .cmd_type          (s_tdata[2:0]),
        .cmd_code          (s_tdata[10:3]),
        .body_length       (s_tdata[18:11]),
        .wait_ms           (s_tdata[50:19]),
        .retry_count       (s_tdata[58:51]),
        .now_ms            (s_tdata[90:59]),
        .pkt_type          (s_tdata[93:91]),
        .pkt_cmd           (s_tdata[101:94]),
        .pkt_seq           (s_tdata[109:102]),
        .pkt_src           (s_tdata[117:110]),
        .pkt_dst           (s_tdata[125:118]),
        .broadcast_address (bcast_address_reg),
        .item              (front_item)
    );

    assign s_tready = !q_full;

    crt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_item  (q_item)
    );

    crt_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .hub_address (hub_address_reg),
        .q_empty     (q_empty),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res         (res)
    );

    assign m_tdata = {7'd0, res.busy_res, res.done_result, res.done_valid,
                      res.tx_seq, res.tx_cmd, res.tx_type, res.tx_dst,
                      res.tx_valid, res.accepted};

endmodule
`default_nettype wire
